@@ hdl/tree_lowest_common_ancestor_macros.svh @@
// ----------------------------------------------------------------------------
// tree lowest common ancestor assertion macros
// shared concurrent assertion forms, compiled out under ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef TREE_LOWEST_COMMON_ANCESTOR_MACROS_SVH
`define TREE_LOWEST_COMMON_ANCESTOR_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TLCA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TLCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TLCA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define TLCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/tlca_pkg.sv @@
// ----------------------------------------------------------------------------
// tlca_pkg
// shared types and codes of the lowest common ancestor block
// ----------------------------------------------------------------------------
package tlca_pkg;

   localparam int NODE_W = 10;
   localparam int STAT_W = 2;
   localparam int OP_W   = 2;
   localparam int CFG_W  = 11;

   localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_APART = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_EDGE,
      CMD_BUILD,
      CMD_QUERY,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } cmd_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_E_CHK,
      S_E_CMP,
      S_E_WALK,
      S_B_RD,
      S_B_EV,
      S_L_RD1,
      S_L_RD2,
      S_L_WR,
      S_Q_DP,
      S_Q_DQ,
      S_Q_LIFT,
      S_Q_LIFTW,
      S_Q_RDP,
      S_Q_RDQ,
      S_Q_EV,
      S_Q_FP,
      S_Q_FQ,
      S_Q_FEV,
      S_RESP
   } state_type;

endpackage

@@ hdl/tlca_ram.sv @@
// ----------------------------------------------------------------------------
// tlca_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tlca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/tlca_front.sv @@
// ----------------------------------------------------------------------------
// tlca_front
// accepts requests, range checks them and classifies them into commands
// ----------------------------------------------------------------------------
module tlca_front #(
   parameter int MAX_NODES = 1024
) (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tlca_pkg::req_type                 req_data,
   input  logic [$clog2(MAX_NODES+1)-1:0]    node_count,
   input  logic                              clearing,
   input  logic                              q_full,
   output logic                              push,
   output tlca_pkg::cmd_type                 push_data
);

   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int KW = (CW > tlca_pkg::NODE_W) ? CW : tlca_pkg::NODE_W;

   logic a_ok;
   logic b_ok;

   assign a_ok = KW'(req_data.node_a) < KW'(node_count);
   assign b_ok = KW'(req_data.node_b) < KW'(node_count);

   always_comb begin
      push_data.node_a = req_data.node_a;
      push_data.node_b = req_data.node_b;
      case (req_data.operation)
         tlca_pkg::OP_EDGE: begin
            push_data.kind = (a_ok && b_ok && (req_data.node_a != req_data.node_b)) ?
                             tlca_pkg::CMD_EDGE : tlca_pkg::CMD_REJECT;
         end
         tlca_pkg::OP_BUILD: begin
            push_data.kind = tlca_pkg::CMD_BUILD;
         end
         tlca_pkg::OP_QUERY: begin
            push_data.kind = (a_ok && b_ok) ? tlca_pkg::CMD_QUERY : tlca_pkg::CMD_REJECT;
         end
         default: begin
            push_data.kind = tlca_pkg::CMD_REJECT;
         end
      endcase
   end

   // no intake while the parent table is being cleared
   assign req_ready = !q_full && !clearing;
   assign push      = req_valid && req_ready;

endmodule

@@ hdl/tlca_queue.sv @@
// ----------------------------------------------------------------------------
// tlca_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module tlca_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tlca_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tlca_pkg::cmd_type head_data
);

   tlca_pkg::cmd_type ent_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = ent_ff[rd_ptr_ff];

endmodule

@@ hdl/tlca_back.sv @@
// ----------------------------------------------------------------------------
// tlca_back
// executes commands: edge load, table build and ancestor query
// ----------------------------------------------------------------------------
`include "tree_lowest_common_ancestor_macros.svh"

module tlca_back #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(MAX_NODES+1)-1:0] node_count,
   input  logic                           cfg_write,
   input  logic                           cmd_valid,
   input  tlca_pkg::cmd_type              cmd_data,
   output logic                           cmd_pop,
   output logic                           clearing,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tlca_pkg::rsp_type              rsp_data
);

   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int NW = $clog2(MAX_NODES);
   localparam int LW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int AW = NW + LW;
   localparam int ADEPTH = 1 << AW;
   localparam logic [LW-1:0] TOP = LW'(LIFT_LEVELS - 1);

   tlca_pkg::state_type state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] a_ff, a_in;
   logic [NW-1:0] b_ff, b_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] i_ff, i_in;
   logic [NW-1:0] steps_ff, steps_in;
   logic [NW-1:0] p_ff, p_in;
   logic [NW-1:0] q_ff, q_in;
   logic [NW-1:0] x_ff, x_in;
   logic [NW-1:0] diff_ff, diff_in;
   logic [LW-1:0] lv_ff, lv_in;
   logic          built_ff, built_in;
   tlca_pkg::rsp_type res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tlca_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          par_we;
   logic [NW-1:0] par_waddr, par_raddr;
   logic [NW:0]   par_wdata, par_rdata;
   logic          dep_we;
   logic [NW-1:0] dep_waddr, dep_raddr, dep_wdata, dep_rdata;
   logic          anc_we;
   logic [AW-1:0] anc_waddr, anc_raddr;
   logic [NW-1:0] anc_wdata, anc_rdata;

   logic [NW-1:0] eff;
   logic          i_last;
   logic [LW-1:0] lv_m1;

   tlca_ram #(.WIDTH(NW + 1), .DEPTH(MAX_NODES)) u_par_ram (
      .clock(clock), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
      .raddr(par_raddr), .rdata(par_rdata)
   );

   tlca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_dep_ram (
      .clock(clock), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
      .raddr(dep_raddr), .rdata(dep_rdata)
   );

   tlca_ram #(.WIDTH(NW), .DEPTH(ADEPTH)) u_anc_ram (
      .clock(clock), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
      .raddr(anc_raddr), .rdata(anc_rdata)
   );

   // parent as a build sees it: absent or stale links point back to the node
   assign eff = (par_rdata[NW] && (CW'(par_rdata[NW-1:0]) < node_count)) ?
                par_rdata[NW-1:0] : cur_ff;
   assign i_last = CW'(i_ff) == (node_count - CW'(1));
   assign lv_m1  = lv_ff - LW'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      i_in         = i_ff;
      steps_in     = steps_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      x_in         = x_ff;
      diff_in      = diff_ff;
      lv_in        = lv_ff;
      built_in     = cfg_write ? 1'b0 : built_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      par_we       = 1'b0;
      par_waddr    = b_ff;
      par_wdata    = {1'b1, a_ff};
      par_raddr    = cur_ff;
      dep_we       = 1'b0;
      dep_waddr    = i_ff;
      dep_wdata    = steps_ff;
      dep_raddr    = q_ff;
      anc_we       = 1'b0;
      anc_waddr    = {i_ff, lv_ff};
      anc_wdata    = anc_rdata;
      anc_raddr    = {p_ff, lv_ff};

      case (state_ff)
         tlca_pkg::S_CLEAR: begin
            par_we    = 1'b1;
            par_waddr = clr_ff;
            par_wdata = '0;
            if (clr_ff == NW'(MAX_NODES - 1)) begin
               state_in = tlca_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + NW'(1);
            end
         end
         tlca_pkg::S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               a_in    = NW'(cmd_data.node_a);
               b_in    = NW'(cmd_data.node_b);
               p_in    = NW'(cmd_data.node_a);
               q_in    = NW'(cmd_data.node_b);
               par_raddr = NW'(cmd_data.node_b);
               dep_raddr = NW'(cmd_data.node_a);
               res_in.ancestor = '0;
               res_in.status   = tlca_pkg::ST_BAD;
               case (cmd_data.kind)
                  tlca_pkg::CMD_EDGE: begin
                     state_in = tlca_pkg::S_E_CHK;
                  end
                  tlca_pkg::CMD_BUILD: begin
                     i_in     = '0;
                     cur_in   = '0;
                     steps_in = '0;
                     state_in = tlca_pkg::S_B_RD;
                  end
                  tlca_pkg::CMD_QUERY: begin
                     state_in = built_ff ? tlca_pkg::S_Q_DP : tlca_pkg::S_RESP;
                  end
                  default: begin
                     state_in = tlca_pkg::S_RESP;
                  end
               endcase
            end
         end
         // edge load: child must be parentless, child not above parent
         tlca_pkg::S_E_CHK: begin
            if (par_rdata[NW]) begin
               state_in = tlca_pkg::S_RESP;
            end else begin
               cur_in   = a_ff;
               state_in = tlca_pkg::S_E_CMP;
            end
         end
         tlca_pkg::S_E_CMP: begin
            if (cur_ff == b_ff) begin
               state_in = tlca_pkg::S_RESP;
            end else begin
               par_raddr = cur_ff;
               state_in  = tlca_pkg::S_E_WALK;
            end
         end
         tlca_pkg::S_E_WALK: begin
            if (!par_rdata[NW]) begin
               par_we        = 1'b1;
               built_in      = 1'b0;
               res_in.status = tlca_pkg::ST_OK;
               state_in      = tlca_pkg::S_RESP;
            end else begin
               cur_in   = par_rdata[NW-1:0];
               state_in = tlca_pkg::S_E_CMP;
            end
         end
         // build: depth walk and level zero
         tlca_pkg::S_B_RD: begin
            par_raddr = cur_ff;
            state_in  = tlca_pkg::S_B_EV;
         end
         tlca_pkg::S_B_EV: begin
            if (steps_ff == '0) begin
               anc_we    = 1'b1;
               anc_waddr = {i_ff, LW'(0)};
               anc_wdata = eff;
            end
            if (eff == cur_ff) begin
               dep_we = 1'b1;
               if (i_last) begin
                  if (LIFT_LEVELS > 1) begin
                     lv_in    = LW'(1);
                     i_in     = '0;
                     state_in = tlca_pkg::S_L_RD1;
                  end else begin
                     built_in      = 1'b1;
                     res_in.status = tlca_pkg::ST_OK;
                     state_in      = tlca_pkg::S_RESP;
                  end
               end else begin
                  i_in     = i_ff + NW'(1);
                  cur_in   = i_ff + NW'(1);
                  steps_in = '0;
                  state_in = tlca_pkg::S_B_RD;
               end
            end else begin
               cur_in   = eff;
               steps_in = steps_ff + NW'(1);
               state_in = tlca_pkg::S_B_RD;
            end
         end
         // build: higher levels, doubling the level below
         tlca_pkg::S_L_RD1: begin
            anc_raddr = {i_ff, lv_m1};
            state_in  = tlca_pkg::S_L_RD2;
         end
         tlca_pkg::S_L_RD2: begin
            anc_raddr = {anc_rdata, lv_m1};
            state_in  = tlca_pkg::S_L_WR;
         end
         tlca_pkg::S_L_WR: begin
            anc_we   = 1'b1;
            state_in = tlca_pkg::S_L_RD1;
            if (i_last) begin
               i_in = '0;
               if (lv_ff == TOP) begin
                  built_in      = 1'b1;
                  res_in.status = tlca_pkg::ST_OK;
                  state_in      = tlca_pkg::S_RESP;
               end else begin
                  lv_in = lv_ff + LW'(1);
               end
            end else begin
               i_in = i_ff + NW'(1);
            end
         end
         // query: depths, then even out
         tlca_pkg::S_Q_DP: begin
            x_in      = dep_rdata;
            dep_raddr = q_ff;
            state_in  = tlca_pkg::S_Q_DQ;
         end
         tlca_pkg::S_Q_DQ: begin
            if (x_ff < dep_rdata) begin
               p_in    = q_ff;
               q_in    = p_ff;
               diff_in = dep_rdata - x_ff;
            end else begin
               diff_in = x_ff - dep_rdata;
            end
            lv_in    = TOP;
            state_in = tlca_pkg::S_Q_LIFT;
         end
         tlca_pkg::S_Q_LIFT: begin
            if (diff_ff == '0) begin
               if (p_ff == q_ff) begin
                  res_in.ancestor = tlca_pkg::NODE_W'(p_ff);
                  res_in.status   = tlca_pkg::ST_OK;
                  state_in        = tlca_pkg::S_RESP;
               end else begin
                  lv_in    = TOP;
                  state_in = tlca_pkg::S_Q_RDP;
               end
            end else if ((diff_ff >> lv_ff) != '0) begin
               anc_raddr = {p_ff, lv_ff};
               diff_in   = diff_ff - (NW'(1) << lv_ff);
               state_in  = tlca_pkg::S_Q_LIFTW;
            end else begin
               lv_in = lv_m1;
            end
         end
         tlca_pkg::S_Q_LIFTW: begin
            p_in     = anc_rdata;
            state_in = tlca_pkg::S_Q_LIFT;
         end
         // query: lift both while ancestors differ
         tlca_pkg::S_Q_RDP: begin
            anc_raddr = {p_ff, lv_ff};
            state_in  = tlca_pkg::S_Q_RDQ;
         end
         tlca_pkg::S_Q_RDQ: begin
            x_in      = anc_rdata;
            anc_raddr = {q_ff, lv_ff};
            state_in  = tlca_pkg::S_Q_EV;
         end
         tlca_pkg::S_Q_EV: begin
            state_in = tlca_pkg::S_Q_RDP;
            if (x_ff != anc_rdata) begin
               p_in = x_ff;
               q_in = anc_rdata;
               if (lv_ff == TOP) begin
                  // both at their roots: separate trees, no progress left
                  if ((x_ff == p_ff) && (anc_rdata == q_ff)) begin
                     state_in = tlca_pkg::S_Q_FP;
                  end
               end else if (lv_ff == '0) begin
                  state_in = tlca_pkg::S_Q_FP;
               end else begin
                  lv_in = lv_m1;
               end
            end else if (lv_ff == '0) begin
               state_in = tlca_pkg::S_Q_FP;
            end else begin
               lv_in = lv_m1;
            end
         end
         tlca_pkg::S_Q_FP: begin
            anc_raddr = {p_ff, LW'(0)};
            state_in  = tlca_pkg::S_Q_FQ;
         end
         tlca_pkg::S_Q_FQ: begin
            x_in      = anc_rdata;
            anc_raddr = {q_ff, LW'(0)};
            state_in  = tlca_pkg::S_Q_FEV;
         end
         tlca_pkg::S_Q_FEV: begin
            if (x_ff == anc_rdata) begin
               res_in.ancestor = tlca_pkg::NODE_W'(x_ff);
               res_in.status   = tlca_pkg::ST_OK;
            end else begin
               res_in.status = tlca_pkg::ST_APART;
            end
            state_in = tlca_pkg::S_RESP;
         end
         tlca_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = tlca_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tlca_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlca_pkg::S_CLEAR;
         clr_ff       <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_ff      <= cur_in;
      i_ff        <= i_in;
      steps_ff    <= steps_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      x_ff        <= x_in;
      diff_ff     <= diff_in;
      lv_ff       <= lv_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign clearing  = state_ff == tlca_pkg::S_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TLCA_ASSERT_IMPL(a_built_src, clock, reset, $rose(built_ff), $past(state_ff == tlca_pkg::S_B_EV) || $past(state_ff == tlca_pkg::S_L_WR), "tables marked built outside a build")
   `TLCA_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid_ff, (rsp_data_ff.status == tlca_pkg::ST_OK) || (rsp_data_ff.ancestor == '0), "error result with nonzero ancestor")
   `TLCA_ASSERT_IMPL(a_diff_down, clock, reset, state_ff == tlca_pkg::S_Q_LIFTW, diff_ff < $past(diff_ff), "depth difference did not shrink")

endmodule

@@ hdl/tree_lowest_common_ancestor.sv @@
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor
// forest parent table with binary-lifting lowest common ancestor queries
// ----------------------------------------------------------------------------
//
//   channel  direction  payload            transaction moves
//   req_     in         req_type           load edge, build, or query
//   rsp_     out        rsp_type           ancestor and status, one per req
//   csr_     in         11-bit node_count  clamped node count write
//
// after reset the parent table is swept clear, entry by entry, with req_ready low
// edge load: reads the child's parent link, then walks up from the parent (cycle check)
// build: per node a walk of parent links on the parent table read port, then per
//   node per level above zero two reads and a write on the lifting table
// query: reads both depths, lifts the deeper node level by level to even them, then
//   compares ancestors from the top level down, limited by the lifting table read port
// a finished result waits in the rsp_ register; the two-entry queue then fills
//   and req_ready drops
// ----------------------------------------------------------------------------
module tree_lowest_common_ancestor #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tlca_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tlca_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [tlca_pkg::CFG_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int KW = (CW > tlca_pkg::CFG_W) ? CW : tlca_pkg::CFG_W;
   localparam int NC_RESET = (MAX_NODES < 1024) ? MAX_NODES : 1024;

   logic [CW-1:0]     node_count_ff;
   logic [CW-1:0]     node_count_in;
   logic              cfg_write;
   logic              clearing;
   logic              q_full;
   logic              push;
   tlca_pkg::cmd_type push_data;
   logic              pop;
   logic              head_valid;
   tlca_pkg::cmd_type head_data;

   // config writes are always taken
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   // clamp the written count into 1..MAX_NODES
   always_comb begin
      node_count_in = node_count_ff;
      if (cfg_write) begin
         if (csr_data == '0) begin
            node_count_in = CW'(1);
         end else if (KW'(csr_data) > KW'(MAX_NODES)) begin
            node_count_in = CW'(MAX_NODES);
         end else begin
            node_count_in = CW'(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CW'(NC_RESET);
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // front: classify and range check
   tlca_front #(.MAX_NODES(MAX_NODES)) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .node_count(node_count_ff),
      .clearing  (clearing),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   tlca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   // back: table walks, build and query engine
   tlca_back #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .node_count(node_count_ff),
      .cfg_write (cfg_write),
      .cmd_valid (head_valid),
      .cmd_data  (head_data),
      .cmd_pop   (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
